// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== sv/isrf_pkg.sv =====
// Types and constants of the sensor register file with sample FIFO.
`timescale 1ns / 1ps
package isrf_pkg;
    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_CNT_LO,
        S_CNT_HI,
        S_REQ,
        S_OUT,
        S_DONE
    } t_state;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_UNDERRUN  = 2'd1;
    localparam logic [1:0] STAT_DROP_ONE  = 2'd2;
    localparam logic [1:0] STAT_DROP_BOTH = 2'd3;

    localparam logic [7:0] PKT_HEADER = 8'h68;
    localparam logic [7:0] PKT_TEMP   = 8'd21;
    localparam int PACKET_BYTES = 16;
endpackage

// ===== sv/isrf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module isrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

// ===== sv/imu_spi_register_fifo.sv =====
// Sensor register file and sample FIFO: top level with request sequencer.
// A register write or a CMD_NONE request goes straight to its result; a sample push writes
// 0, 16 or 32 FIFO bytes, then the low and high count bytes, and then shows its result.
// A burst read fetches each byte from the registered RAM, then shows it, held by i_out_stall;
// a FIFO read first writes both count bytes. One request is in work at a time.
// Reset clears control state and marks all register bytes as zero; FIFO data is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module imu_spi_register_fifo
    import isrf_pkg::*;
#(
    parameter int FIFO_BYTES = 2048,
    parameter int MAX_BURST  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [6:0]  i_register_address,
    input  logic [7:0]  i_write_data,
    input  logic [5:0]  i_read_length,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_rate_x,
    input  logic signed [15:0] i_rate_y,
    input  logic signed [15:0] i_rate_z,
    input  logic [15:0] i_time_stamp,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic [1:0]  o_status,
    output logic        o_last
);
    localparam int PW = $clog2(FIFO_BYTES);
    localparam int CW = $clog2(FIFO_BYTES + 1);
    localparam int LW = $clog2(MAX_BURST + 1);
    localparam logic [CW:0] FULL = (CW + 1)'(FIFO_BYTES);

    t_state            r_state, n_state;
    logic              r_push, n_push;
    logic              r_fifo, n_fifo;
    logic              r_second, n_second;
    logic [1:0]        r_status, n_status;
    logic [127:0]      r_pkt, n_pkt;
    logic [3:0]        r_idx, n_idx;
    logic [6:0]        r_addr, n_addr;
    logic [LW-1:0]     r_left, n_left;
    logic [PW-1:0]     r_rp, n_rp;
    logic [PW-1:0]     r_wp, n_wp;
    logic [CW-1:0]     r_count, n_count;
    logic [127:0]      r_reg_vld, n_reg_vld;
    logic              r_vld_q, n_vld_q;
    logic [6:0]        r_fifo_addr;
    logic [6:0]        r_count_addr;

    logic              f_we, f_re;
    logic [PW-1:0]     f_wa, f_ra;
    logic [7:0]        f_wd, f_q;
    logic              g_we, g_re;
    logic [6:0]        g_wa, g_ra;
    logic [7:0]        g_wd, g_q;

    logic [LW-1:0]     len_sat;
    logic [15:0]       cnt16;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(FIFO_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    isrf_ram #(.WIDTH(8), .DEPTH(FIFO_BYTES)) u_fifo_ram (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_wa), .i_wdata(f_wd),
        .i_re(f_re), .i_raddr(f_ra), .o_rdata(f_q)
    );

    isrf_ram #(.WIDTH(8), .DEPTH(128)) u_reg_ram (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_wa), .i_wdata(g_wd),
        .i_re(g_re), .i_raddr(g_ra), .o_rdata(g_q)
    );

    always_comb begin
        len_sat = (7'(i_read_length) > 7'(MAX_BURST)) ? LW'(MAX_BURST) : LW'(i_read_length);
        cnt16   = 16'(r_count >> 4);
    end

    always_comb begin
        n_state   = r_state;
        n_push    = r_push;
        n_fifo    = r_fifo;
        n_second  = r_second;
        n_status  = r_status;
        n_pkt     = r_pkt;
        n_idx     = r_idx;
        n_addr    = r_addr;
        n_left    = r_left;
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_count   = r_count;
        n_reg_vld = r_reg_vld;
        n_vld_q   = r_vld_q;
        f_we = 1'b0;
        f_wa = r_wp;
        f_wd = r_pkt[{r_idx, 3'b000} +: 8];
        f_re = 1'b0;
        f_ra = r_rp;
        g_we = 1'b0;
        g_wa = i_register_address;
        g_wd = i_write_data;
        g_re = 1'b0;
        g_ra = r_addr;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = STAT_OK;
                    unique case (t_cmd'(i_command))
                        CMD_PUSH: begin
                            n_pkt    = {i_time_stamp, PKT_TEMP, i_rate_z, i_rate_y, i_rate_x,
                                        i_accel_z, i_accel_y, i_accel_x, PKT_HEADER};
                            n_push   = 1'b1;
                            n_idx    = '0;
                            n_second = 1'b0;
                            if ({1'b0, r_count} + (CW + 1)'(PACKET_BYTES) > FULL) begin
                                n_status = STAT_DROP_BOTH;
                                n_state  = S_CNT_LO;
                            end else begin
                                n_state = S_PUSH;
                            end
                        end
                        CMD_WRITE: begin
                            g_we = 1'b1;
                            n_reg_vld[i_register_address] = 1'b1;
                            n_state = S_DONE;
                        end
                        CMD_READ: begin
                            n_push = 1'b0;
                            n_addr = i_register_address;
                            n_left = len_sat;
                            if (len_sat == '0) begin
                                n_state = S_DONE;
                            end else if (i_register_address == r_fifo_addr) begin
                                if ((CW + 1)'(len_sat) > {1'b0, r_count}) begin
                                    n_status = STAT_UNDERRUN;
                                    n_state  = S_DONE;
                                end else begin
                                    n_fifo  = 1'b1;
                                    n_count = r_count - CW'(len_sat);
                                    n_state = S_CNT_LO;
                                end
                            end else begin
                                n_fifo  = 1'b0;
                                n_state = S_REQ;
                            end
                        end
                        CMD_NONE: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                f_we  = 1'b1;
                n_wp  = ptr_inc(r_wp);
                n_idx = r_idx + 1'b1;
                if (r_idx == 4'hf) begin
                    n_count = r_count + CW'(PACKET_BYTES);
                    if (r_second) begin
                        n_state = S_CNT_LO;
                    end else if ({1'b0, r_count} + (CW + 1)'(2 * PACKET_BYTES) > FULL) begin
                        n_status = STAT_DROP_ONE;
                        n_state  = S_CNT_LO;
                    end else begin
                        n_second = 1'b1;
                    end
                end
            end
            S_CNT_LO: begin
                g_we = 1'b1;
                g_wa = r_count_addr;
                g_wd = cnt16[7:0];
                n_reg_vld[r_count_addr] = 1'b1;
                n_state = S_CNT_HI;
            end
            S_CNT_HI: begin
                g_we = 1'b1;
                g_wa = r_count_addr + 7'd1;
                g_wd = cnt16[15:8];
                n_reg_vld[r_count_addr + 7'd1] = 1'b1;
                n_state = r_push ? S_DONE : S_REQ;
            end
            S_REQ: begin
                f_re    = r_fifo;
                g_re    = !r_fifo;
                n_vld_q = r_reg_vld[r_addr];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_fifo) begin
                        n_rp = ptr_inc(r_rp);
                    end else begin
                        n_addr = r_addr + 7'd1;
                    end
                    n_left  = r_left - 1'b1;
                    n_state = (r_left == LW'(1)) ? S_IDLE : S_REQ;
                end
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rp      <= '0;
            r_wp      <= '0;
            r_count   <= '0;
            r_reg_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_rp      <= n_rp;
            r_wp      <= n_wp;
            r_count   <= n_count;
            r_reg_vld <= n_reg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_push   <= n_push;
        r_fifo   <= n_fifo;
        r_second <= n_second;
        r_status <= n_status;
        r_pkt    <= n_pkt;
        r_idx    <= n_idx;
        r_addr   <= n_addr;
        r_left   <= n_left;
        r_vld_q  <= n_vld_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_addr  <= 7'd48;
            r_count_addr <= 7'd46;
        end else if (i_cfg_we) begin
            if (i_cfg_index) begin
                r_count_addr <= i_cfg_data;
            end else begin
                r_fifo_addr <= i_cfg_data;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE) || (r_state == S_OUT);
    assign o_read_data = (r_state != S_OUT) ? 8'd0 :
                         r_fifo ? f_q : (r_vld_q ? g_q : 8'd0);
    assign o_status    = (r_state == S_DONE) ? r_status : STAT_OK;
    assign o_last      = (r_state == S_DONE) || ((r_state == S_OUT) && (r_left == LW'(1)));

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, {1'b0, r_count} <= FULL,
                   "FIFO count exceeds capacity")
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall,
                 o_in_stall, "request accepted without going busy")
    `ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_last,
                 !o_in_stall && !o_out_valid, "sequencer not idle after final result")
    `ASSERT_IMPLIES(a_result_while_busy, i_clk, i_rst_n, o_out_valid, o_in_stall,
                    "result shown while taking requests")
endmodule
